// File: hw/rtl/ttba_pkg.sv
// shared types, codes and helpers of the trade time bucket aggregator
package ttba_pkg;

  localparam int unsigned NumBucketsDefault = 4096;
  localparam int unsigned CntW = 32;
  localparam int unsigned WordW = 64;
  localparam int unsigned NumWords = 12;

  // item commands
  localparam logic [1:0] CMD_TRADE = 2'd0;
  localparam logic [1:0] CMD_READ_BUCKET = 2'd1;
  localparam logic [1:0] CMD_READ_SUMMARY = 2'd2;

  // aggressor sides
  localparam logic [1:0] SIDE_BUY = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;
  localparam logic [1:0] SIDE_UNKNOWN = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OUTSIDE = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_BAD_GRID = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_DAY_START = 2'd0;
  localparam logic [1:0] REG_DAY_END = 2'd1;
  localparam logic [1:0] REG_GRID = 2'd2;

  // last word number of each read-out
  localparam logic [3:0] LAST_TRADE = 4'd0;
  localparam logic [3:0] LAST_BUCKET = 4'd8;
  localparam logic [3:0] LAST_SUMMARY = 4'd11;

  typedef enum logic [0:0] {
    OP_DIV,
    OP_MUL
  } iter_op_e;

  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [63:0] a;
    logic [63:0] b;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
    logic        ovf;
  } iter_rsp_t;

  typedef struct packed {
    logic [62:0]     buy_lots;
    logic [62:0]     buy_notional;
    logic [CntW-1:0] buy_count;
    logic [62:0]     sell_lots;
    logic [62:0]     sell_notional;
    logic [CntW-1:0] sell_count;
    logic [CntW-1:0] total_count;
    logic [63:0]     latest_time;
    logic [63:0]     latest_arrival;
  } bucket_row_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPAN_DIV,
    S_OFFS_DIV,
    S_MUL,
    S_UPDATE,
    S_EMIT
  } state_e;

  // saturating counter step
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (&c) ? c : c + CntW'(1);
  endfunction

endpackage

// File: hw/rtl/trade_time_bucket_aggregator.sv
// top level: trade time bucket aggregator with sequencer and summary counters
// Input items arrive on the s_axis stream: tuser carries the command, tdata the
// trade fields and the bucket to read. Results leave on the m_axis stream as 64-bit
// words, one per trade, 9 per bucket read and 12 per summary read, tlast on the final word of each input item.
// Three 64-bit registers (day start, day end, grid interval) sit on the APB port
// at byte addresses 0, 8 and 16; write them only while the block is idle.
// After reset the bucket memory is cleared one row a cycle, all NUM_BUCKETS rows,
// during which s_axis_tready stays low; register writes are taken as ever.
// A trade runs two 64-step divisions (day span by interval, then trade offset by interval)
// and one 64-step notional multiply, all on the one shared shift and add unit, with
// checks after each division and the multiply, and the row update at the end.
// Bad grid and invalid trades finish after the first division or at once.
// A bucket read or a summary read emits its words (9 or 12) one per cycle while the receiver takes them.
// The block takes one item at a time; s_axis_tready is high only when idle.
// A finished result sits in the output register while the next item is taken;
// when the receiver stalls, the sequencer waits with the next word.
module trade_time_bucket_aggregator #(
  parameter int unsigned NUM_BUCKETS = ttba_pkg::NumBucketsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // event_time[63:0], arrival_time[127:64], aggressor[129:128],
  // price_steps[192:130], quantity_steps[255:193], bucket_select[267:256]
  input  logic [271:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // word_value[63:0]
  output logic [63:0]  m_axis_tdata,
  // status[2:0], word_index[6:3]
  output logic [6:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CW = ttba_pkg::CntW;

  ttba_pkg::state_e state_q, state_d;

  logic [BW-1:0] clr_q;
  logic [63:0]   day_start_q, day_end_q, grid_q;

  logic [1:0]  cmd_q, cmd_d;
  logic [63:0] ev_q, ev_d, ar_q, ar_d;
  logic [1:0]  side_q, side_d;
  logic [62:0] price_q, price_d, qty_q, qty_d;
  logic        rd_oor_q, rd_oor_d;
  logic [63:0] count_q, count_d;
  logic [BW-1:0] idx_q, idx_d;
  logic [62:0] notional_q, notional_d;
  logic [2:0]  res_status_q, res_status_d;
  logic [63:0] res_value_q, res_value_d;
  logic [3:0]  word_q, word_d;

  logic [CW-1:0] row_cnt_q, row_cnt_d;
  logic [63:0]   first_ev_q, first_ev_d, first_ar_q, first_ar_d;
  logic [63:0]   latest_ev_q, latest_ev_d, latest_ar_q, latest_ar_d;
  logic [CW-1:0] ev_regr_q, ev_regr_d, ar_regr_q, ar_regr_d;
  logic [CW-1:0] side_cnt_q [3];
  logic [CW-1:0] side_cnt_d [3];
  logic [CW-1:0] outside_q, outside_d;
  logic          sticky_q, sticky_d;

  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic [6:0]  m_user_q;
  logic        m_last_q;

  ttba_pkg::iter_req_t   iter_req;
  ttba_pkg::iter_rsp_t   iter_rsp;
  ttba_pkg::bucket_row_t mem_rdata, mem_wdata, upd_row;
  logic                  mem_we, mem_re;
  logic [BW-1:0]         mem_waddr, mem_raddr;

  logic        in_acc, cfg_we, out_load, grid_bad_early, in_day;
  logic [63:0] span, offset;
  logic [64:0] idx_full;
  logic [63:0] lots_sum, not_sum;
  logic [62:0] side_lots, side_not;
  logic        upd_ovf;
  logic [3:0]  last_word;
  logic [1:0]  in_side;
  logic [63:0] words [ttba_pkg::NumWords];

  assign in_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready  = (state_q == ttba_pkg::S_IDLE);
  assign cfg_we         = psel && penable && pwrite;
  assign pready         = 1'b1;
  assign span           = day_end_q - day_start_q;
  assign offset         = ev_q - day_start_q;
  assign grid_bad_early = (day_end_q <= day_start_q) || (grid_q == '0);
  assign in_day         = (ev_q >= day_start_q) && (ev_q < day_end_q);
  assign idx_full       = {1'b0, iter_rsp.quot} + {64'd0, (iter_rsp.rem != '0)};
  assign in_side        = (s_axis_tdata[129:128] == 2'd3) ? ttba_pkg::SIDE_UNKNOWN
                                                          : s_axis_tdata[129:128];
  assign out_load       = (state_q == ttba_pkg::S_EMIT) && (!m_valid_q || m_axis_tready);

  // configuration registers and read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_start_q <= '0;
      day_end_q   <= '0;
      grid_q      <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        ttba_pkg::REG_DAY_START: day_start_q <= pwdata;
        ttba_pkg::REG_DAY_END:   day_end_q   <= pwdata;
        ttba_pkg::REG_GRID:      grid_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      ttba_pkg::REG_DAY_START: prdata = day_start_q;
      ttba_pkg::REG_DAY_END:   prdata = day_end_q;
      ttba_pkg::REG_GRID:      prdata = grid_q;
      default:                 prdata = '0;
    endcase
  end

  // shared divide and multiply unit
  ttba_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  // bucket rows
  ttba_bucket_mem #(
    .Depth (NUM_BUCKETS),
    .AddrW (BW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // side fields of the bucket row and their overflow test
  always_comb begin
    side_lots = (side_q == ttba_pkg::SIDE_BUY) ? mem_rdata.buy_lots : mem_rdata.sell_lots;
    side_not  = (side_q == ttba_pkg::SIDE_BUY) ? mem_rdata.buy_notional
                                               : mem_rdata.sell_notional;
    lots_sum  = {1'b0, side_lots} + {1'b0, qty_q};
    not_sum   = {1'b0, side_not} + {1'b0, notional_q};
    upd_ovf   = (side_q != ttba_pkg::SIDE_UNKNOWN) && (lots_sum[63] || not_sum[63]);
    upd_row   = mem_rdata;
    if (side_q == ttba_pkg::SIDE_BUY) begin
      upd_row.buy_lots     = lots_sum[62:0];
      upd_row.buy_notional = not_sum[62:0];
      upd_row.buy_count    = ttba_pkg::sat_inc(mem_rdata.buy_count);
    end else if (side_q == ttba_pkg::SIDE_SELL) begin
      upd_row.sell_lots     = lots_sum[62:0];
      upd_row.sell_notional = not_sum[62:0];
      upd_row.sell_count    = ttba_pkg::sat_inc(mem_rdata.sell_count);
    end
    upd_row.total_count    = ttba_pkg::sat_inc(mem_rdata.total_count);
    upd_row.latest_time    = ev_q;
    upd_row.latest_arrival = ar_q;
  end

  // read-out words of the current item
  always_comb begin
    for (int i = 0; i < ttba_pkg::NumWords; i++) begin
      words[i] = '0;
    end
    case (cmd_q)
      ttba_pkg::CMD_READ_BUCKET: begin
        last_word = ttba_pkg::LAST_BUCKET;
        if (!rd_oor_q) begin
          words[0] = {1'b0, mem_rdata.buy_lots};
          words[1] = {1'b0, mem_rdata.buy_notional};
          words[2] = 64'(mem_rdata.buy_count);
          words[3] = {1'b0, mem_rdata.sell_lots};
          words[4] = {1'b0, mem_rdata.sell_notional};
          words[5] = 64'(mem_rdata.sell_count);
          words[6] = 64'(mem_rdata.total_count);
          words[7] = mem_rdata.latest_time;
          words[8] = mem_rdata.latest_arrival;
        end
      end
      ttba_pkg::CMD_READ_SUMMARY: begin
        last_word = ttba_pkg::LAST_SUMMARY;
        words[0]  = 64'(row_cnt_q);
        words[1]  = first_ev_q;
        words[2]  = first_ar_q;
        words[3]  = latest_ev_q;
        words[4]  = latest_ar_q;
        words[5]  = 64'(ev_regr_q);
        words[6]  = 64'(ar_regr_q);
        words[7]  = 64'(side_cnt_q[0]);
        words[8]  = 64'(side_cnt_q[1]);
        words[9]  = 64'(side_cnt_q[2]);
        words[10] = 64'(outside_q);
        words[11] = 64'(sticky_q);
      end
      default: begin
        last_word = ttba_pkg::LAST_TRADE;
        words[0]  = res_value_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttba_pkg::S_CLEAR: begin
        if (clr_q == BW'(NUM_BUCKETS - 1)) state_d = ttba_pkg::S_IDLE;
      end
      ttba_pkg::S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            ttba_pkg::CMD_TRADE: begin
              state_d = grid_bad_early ? ttba_pkg::S_EMIT : ttba_pkg::S_SPAN_DIV;
            end
            ttba_pkg::CMD_READ_BUCKET, ttba_pkg::CMD_READ_SUMMARY: state_d = ttba_pkg::S_EMIT;
            default: ;
          endcase
        end
      end
      ttba_pkg::S_SPAN_DIV: begin
        if (iter_rsp.done) begin
          if ((iter_rsp.rem != '0) || (iter_rsp.quot > 64'(NUM_BUCKETS)) ||
              (price_q == '0) || (qty_q == '0) || !in_day) begin
            state_d = ttba_pkg::S_EMIT;
          end else begin
            state_d = ttba_pkg::S_OFFS_DIV;
          end
        end
      end
      ttba_pkg::S_OFFS_DIV: begin
        if (iter_rsp.done) begin
          state_d = (idx_full >= {1'b0, count_q}) ? ttba_pkg::S_EMIT : ttba_pkg::S_MUL;
        end
      end
      ttba_pkg::S_MUL: begin
        if (iter_rsp.done) begin
          state_d = iter_rsp.ovf ? ttba_pkg::S_EMIT : ttba_pkg::S_UPDATE;
        end
      end
      ttba_pkg::S_UPDATE: state_d = ttba_pkg::S_EMIT;
      ttba_pkg::S_EMIT: begin
        if (out_load && (word_q == last_word)) state_d = ttba_pkg::S_IDLE;
      end
      default: state_d = ttba_pkg::S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    cmd_d        = cmd_q;
    ev_d         = ev_q;
    ar_d         = ar_q;
    side_d       = side_q;
    price_d      = price_q;
    qty_d        = qty_q;
    rd_oor_d     = rd_oor_q;
    count_d      = count_q;
    idx_d        = idx_q;
    notional_d   = notional_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    word_d       = word_q;
    row_cnt_d    = row_cnt_q;
    first_ev_d   = first_ev_q;
    first_ar_d   = first_ar_q;
    latest_ev_d  = latest_ev_q;
    latest_ar_d  = latest_ar_q;
    ev_regr_d    = ev_regr_q;
    ar_regr_d    = ar_regr_q;
    side_cnt_d   = side_cnt_q;
    outside_d    = outside_q;
    sticky_d     = sticky_q;
    iter_req     = '0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = upd_row;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;

    case (state_q)
      ttba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ttba_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_d        = s_axis_tuser;
          ev_d         = s_axis_tdata[63:0];
          ar_d         = s_axis_tdata[127:64];
          side_d       = in_side;
          price_d      = s_axis_tdata[192:130];
          qty_d        = s_axis_tdata[255:193];
          word_d       = '0;
          res_value_d  = '0;
          res_status_d = ttba_pkg::ST_OK;
          rd_oor_d     = 1'b0;
          case (s_axis_tuser)
            ttba_pkg::CMD_TRADE: begin
              if (grid_bad_early) begin
                res_status_d = ttba_pkg::ST_BAD_GRID;
              end else begin
                iter_req.start = 1'b1;
                iter_req.op    = ttba_pkg::OP_DIV;
                iter_req.a     = span;
                iter_req.b     = grid_q;
              end
            end
            ttba_pkg::CMD_READ_BUCKET: begin
              if (32'(s_axis_tdata[267:256]) >= 32'(NUM_BUCKETS)) begin
                rd_oor_d     = 1'b1;
                res_status_d = ttba_pkg::ST_OUTSIDE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = BW'(s_axis_tdata[267:256]);
              end
            end
            default: ;
          endcase
        end
      end
      ttba_pkg::S_SPAN_DIV: begin
        if (iter_rsp.done) begin
          count_d = iter_rsp.quot;
          if ((iter_rsp.rem != '0) || (iter_rsp.quot > 64'(NUM_BUCKETS))) begin
            res_status_d = ttba_pkg::ST_BAD_GRID;
          end else if ((price_q == '0) || (qty_q == '0)) begin
            res_status_d = ttba_pkg::ST_INVALID;
          end else begin
            // stream-wide counters see every valid trade
            if (row_cnt_q == '0) begin
              first_ev_d = ev_q;
              first_ar_d = ar_q;
            end else begin
              if (ev_q < latest_ev_q) ev_regr_d = ttba_pkg::sat_inc(ev_regr_q);
              if (ar_q < latest_ar_q) ar_regr_d = ttba_pkg::sat_inc(ar_regr_q);
            end
            row_cnt_d          = ttba_pkg::sat_inc(row_cnt_q);
            latest_ev_d        = ev_q;
            latest_ar_d        = ar_q;
            side_cnt_d[side_q] = ttba_pkg::sat_inc(side_cnt_q[side_q]);
            if (!in_day) begin
              outside_d    = ttba_pkg::sat_inc(outside_q);
              res_status_d = ttba_pkg::ST_OUTSIDE;
            end else begin
              iter_req.start = 1'b1;
              iter_req.op    = ttba_pkg::OP_DIV;
              iter_req.a     = offset;
              iter_req.b     = grid_q;
            end
          end
        end
      end
      ttba_pkg::S_OFFS_DIV: begin
        if (iter_rsp.done) begin
          if (idx_full >= {1'b0, count_q}) begin
            outside_d    = ttba_pkg::sat_inc(outside_q);
            res_status_d = ttba_pkg::ST_OUTSIDE;
          end else begin
            idx_d          = idx_full[BW-1:0];
            res_value_d    = idx_full[63:0];
            mem_re         = 1'b1;
            mem_raddr      = idx_full[BW-1:0];
            iter_req.start = 1'b1;
            iter_req.op    = ttba_pkg::OP_MUL;
            iter_req.a     = {1'b0, qty_q};
            iter_req.b     = {1'b0, price_q};
          end
        end
      end
      ttba_pkg::S_MUL: begin
        if (iter_rsp.done) begin
          notional_d = iter_rsp.rem[62:0];
          if (iter_rsp.ovf) begin
            sticky_d     = 1'b1;
            res_status_d = ttba_pkg::ST_OVERFLOW;
          end
        end
      end
      ttba_pkg::S_UPDATE: begin
        if (upd_ovf) begin
          sticky_d     = 1'b1;
          res_status_d = ttba_pkg::ST_OVERFLOW;
        end else begin
          mem_we = 1'b1;
        end
      end
      ttba_pkg::S_EMIT: begin
        if (out_load) word_d = word_q + 4'd1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttba_pkg::S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      row_cnt_q <= '0;
      first_ev_q <= '0;
      first_ar_q <= '0;
      latest_ev_q <= '0;
      latest_ar_q <= '0;
      ev_regr_q <= '0;
      ar_regr_q <= '0;
      for (int i = 0; i < 3; i++) side_cnt_q[i] <= '0;
      outside_q <= '0;
      sticky_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ttba_pkg::S_CLEAR) clr_q <= clr_q + BW'(1);
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      row_cnt_q   <= row_cnt_d;
      first_ev_q  <= first_ev_d;
      first_ar_q  <= first_ar_d;
      latest_ev_q <= latest_ev_d;
      latest_ar_q <= latest_ar_d;
      ev_regr_q   <= ev_regr_d;
      ar_regr_q   <= ar_regr_d;
      side_cnt_q  <= side_cnt_d;
      outside_q   <= outside_d;
      sticky_q    <= sticky_d;
    end
  end

  // item payload and output register
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ev_q         <= ev_d;
    ar_q         <= ar_d;
    side_q       <= side_d;
    price_q      <= price_d;
    qty_q        <= qty_d;
    rd_oor_q     <= rd_oor_d;
    count_q      <= count_d;
    idx_q        <= idx_d;
    notional_q   <= notional_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    word_q       <= word_d;
    if (out_load) begin
      m_data_q <= words[word_q];
      m_user_q <= {word_q, res_status_q};
      m_last_q <= (word_q == last_word);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // the bucket memory is written only during the clearing pass or a row update
  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ttba_pkg::S_CLEAR) || (state_q == ttba_pkg::S_UPDATE))
    else $error("bucket memory written outside clear or update");

  // the shared unit is never restarted while it is still working
  a_iter_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_req.start |-> !iter_rsp.busy)
    else $error("shared unit started while busy");

  // a word is loaded only into a free or draining output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten");

endmodule

// File: hw/rtl/ttba_iter.sv
// shared shift and add unit: restoring divide or shift-add multiply, one bit a cycle
module ttba_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttba_pkg::iter_req_t req_i,
  output ttba_pkg::iter_rsp_t rsp_o
);

  logic               busy_q, done_q;
  logic [5:0]         cnt_q;
  ttba_pkg::iter_op_e op_q;
  logic [63:0]        d_q;
  logic [63:0]        q_q;
  logic [64:0]        r_q;
  logic               ovf_q;

  logic [64:0] x, y;
  logic        cin;
  logic [65:0] sum;

  // one shared 65-bit adder serves both operations
  always_comb begin
    if (op_q == ttba_pkg::OP_DIV) begin
      x   = {r_q[63:0], q_q[63]};
      y   = ~{1'b0, d_q};
      cin = 1'b1;
    end else begin
      x   = {r_q[63:0], 1'b0};
      y   = q_q[63] ? {1'b0, d_q} : '0;
      cin = 1'b0;
    end
    sum = {1'b0, x} + {1'b0, y} + {65'd0, cin};
  end

  // sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (&cnt_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      d_q   <= req_i.b;
      q_q   <= req_i.a;
      r_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      if (op_q == ttba_pkg::OP_DIV) begin
        if (sum[65]) begin
          r_q <= sum[64:0];
          q_q <= {q_q[62:0], 1'b1};
        end else begin
          r_q <= x;
          q_q <= {q_q[62:0], 1'b0};
        end
      end else begin
        r_q   <= sum[64:0];
        q_q   <= {q_q[62:0], 1'b0};
        ovf_q <= ovf_q | (|sum[64:63]);
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q[63:0];
  assign rsp_o.ovf  = ovf_q;

endmodule

// File: hw/rtl/ttba_bucket_mem.sv
// bucket row memory, one write and one registered read port
module ttba_bucket_mem #(
  parameter int unsigned Depth = ttba_pkg::NumBucketsDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  ttba_pkg::bucket_row_t wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output ttba_pkg::bucket_row_t rdata_o
);

  ttba_pkg::bucket_row_t mem_q [Depth];
  ttba_pkg::bucket_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
